// ===== sv/ffba_pkg.sv =====
package ffba_pkg;

  // heap geometry
  localparam int unsigned HEAP_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned BOOK_BYTES   = 8;
  localparam int unsigned GRAIN_BYTES  = 8;
  localparam int unsigned STORE_DEPTH  = HEAP_BYTES / GRAIN_BYTES;
  localparam int unsigned IDX_W        = $clog2(STORE_DEPTH);
  localparam int unsigned GRAIN_W      = $clog2(GRAIN_BYTES);
  localparam int unsigned SIZE_W       = 17;
  localparam int unsigned OFF_W        = $clog2(HEAP_BYTES) + 4;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;

  // command and status codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_FREE    = 1'b1;
  localparam logic STAT_DONE   = 1'b0;
  localparam logic STAT_NO_FIT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] request_bytes;
    logic [ADDR_W-1:0] object_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_address;
    logic              status;
  } res_t;

  // one block header: occupied flag and block size in bytes
  typedef struct packed {
    logic              occ;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    hdr_t             data;
  } store_wr_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_FIT,
    ST_A_REM,
    ST_A_HDR,
    ST_F_CHK,
    ST_F_CUR,
    ST_F_LRD,
    ST_F_LCHK,
    ST_F_HDR
  } state_t;

endpackage

// ===== sv/ffba_hdr_store.sv =====
module ffba_hdr_store (
  input  logic                    clk,
  input  ffba_pkg::store_wr_t     wr,
  input  logic                    rd_en,
  input  logic [ffba_pkg::IDX_W-1:0] rd_addr,
  output ffba_pkg::hdr_t          rd_data
);
  import ffba_pkg::*;

  hdr_t mem [STORE_DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/first_fit_block_allocator_top.sv =====
// First-fit heap allocator. A request (start while busy is low) either
// allocates request_bytes rounded up to 8 and returns heap_base plus the payload
// offset, or frees the block at object_address and merges the free blocks after
// it. Exactly one result per request appears on out_res for a single cycle with
// out_valid high; the receiver cannot hold it off, so it must be taken then.
// Headers sit in one single-port-read store, and every header visited is
// first read and then checked. busy stays high while an allocate walks the
// headers and while a free merges blocks; a free of a bad address is answered
// from its address check. The result shows in the first cycle with busy low,
// and a new request can be taken in that cycle. After reset the store is
// cleared one entry a cycle, all 8192 entries, while busy stays high;
// configuration writes are taken at any time but belong in idle periods.
module first_fit_block_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ffba_pkg::req_t                  in_req,
  output logic                            out_valid,
  output ffba_pkg::res_t                  out_res,
  input  logic                            cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ffba_pkg::*;

  localparam logic [OFF_W-1:0]  HDR_OFF   = OFF_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0]  BOOK_OFF  = OFF_W'(BOOK_BYTES);
  localparam logic [ADDR_W-1:0] MIN_FREE  = ADDR_W'(BOOK_BYTES + HEADER_BYTES);
  localparam logic [OFF_W-1:0]  HEAP_MAX  = OFF_W'(HEAP_BYTES);
  localparam logic [OFF_W-1:0]  ROUND_ADD = OFF_W'(GRAIN_BYTES - 1);
  localparam logic [OFF_W-1:0]  GRAIN_MSK = ~OFF_W'(GRAIN_BYTES - 1);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] heap_bytes_r;
  logic [ADDR_W-1:0] heap_base_r;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [OFF_W-1:0]  pos_r, pos_nxt;
  logic [OFF_W-1:0]  need_r, need_nxt;
  logic [OFF_W-1:0]  need16_r, need16_nxt;
  logic [OFF_W-1:0]  sz_r, sz_nxt;
  logic [OFF_W-1:0]  rem_r, rem_nxt;
  logic [OFF_W-1:0]  cur_r, cur_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  store_wr_t         st_wr;
  logic              st_rd_en;
  logic [IDX_W-1:0]  st_rd_addr;
  hdr_t              st_rd;

  logic [OFF_W-1:0]  end_off;
  logic [OFF_W-1:0]  rd_size;
  logic [OFF_W-1:0]  walk_sum;
  logic [OFF_W-1:0]  hdr_off;
  logic [OFF_W-1:0]  p_off;
  logic              a_walk_ok, a_take, a_fits, a_split, rem_fits;
  logic              f_addr_ok, f_walk_ok, f_stop, clr_last;

  ffba_hdr_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd)
  );

  // effective heap end, capped at the store size
  assign end_off = (OFF_W'(heap_bytes_r) > HEAP_MAX) ? HEAP_MAX : OFF_W'(heap_bytes_r);

  // shared walk adder: next header offset after the one just read
  assign rd_size  = OFF_W'(st_rd.size);
  assign walk_sum = pos_r + rd_size + HDR_OFF;

  assign p_off    = p_r[OFF_W-1:0];
  assign hdr_off  = p_off - HDR_OFF;

  // decision terms
  assign a_walk_ok = (pos_r + HDR_OFF) < end_off;
  assign a_take    = !st_rd.occ && ((st_rd.size == '0) || (rd_size > need16_r));
  assign a_fits    = (pos_r + need16_r) <= end_off;
  assign a_split   = sz_r > need16_r;
  assign rem_fits  = (rem_r + HDR_OFF) <= end_off;
  assign f_addr_ok = (p_r[GRAIN_W-1:0] == '0) && (p_r >= MIN_FREE)
                     && (p_r <= ADDR_W'(end_off));
  assign f_walk_ok = (pos_r + HDR_OFF) <= end_off;
  assign f_stop    = st_rd.occ || (walk_sum > end_off);
  assign clr_last  = (clr_idx_r == IDX_W'(STORE_DEPTH - 1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= SIZE_W'(HEAP_BYTES);
      heap_base_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAP_BYTES: heap_bytes_r <= cfg_wdata[SIZE_W-1:0];
        CFG_HEAP_BASE:  heap_base_r  <= cfg_wdata[ADDR_W-1:0];
        default:        ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) state_nxt = (in_req.cmd == CMD_FREE) ? ST_F_CHK : ST_A_RD;
      end
      ST_A_RD:   state_nxt = a_walk_ok ? ST_A_CHK : ST_IDLE;
      ST_A_CHK:  state_nxt = a_take ? ST_A_FIT : ST_A_RD;
      ST_A_FIT: begin
        if (!a_fits)      state_nxt = ST_IDLE;
        else if (a_split) state_nxt = ST_A_REM;
        else              state_nxt = ST_A_HDR;
      end
      ST_A_REM:  state_nxt = ST_A_HDR;
      ST_A_HDR:  state_nxt = ST_IDLE;
      ST_F_CHK:  state_nxt = f_addr_ok ? ST_F_CUR : ST_IDLE;
      ST_F_CUR:  state_nxt = ST_F_LRD;
      ST_F_LRD:  state_nxt = f_walk_ok ? ST_F_LCHK : ST_F_HDR;
      ST_F_LCHK: state_nxt = f_stop ? ST_F_HDR : ST_F_LRD;
      ST_F_HDR:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and store control
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    pos_nxt       = pos_r;
    need_nxt      = need_r;
    need16_nxt    = need16_r;
    sz_nxt        = sz_r;
    rem_nxt       = rem_r;
    cur_nxt       = cur_r;
    p_nxt         = p_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    st_wr         = '0;
    st_rd_en      = 1'b0;
    st_rd_addr    = pos_r[GRAIN_W +: IDX_W];
    unique case (state_r)
      ST_CLEAR: begin
        st_wr.en    = 1'b1;
        st_wr.addr  = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ST_IDLE: begin
        // round up once for the size and once with a header added
        need_nxt   = (OFF_W'(in_req.request_bytes) + ROUND_ADD) & GRAIN_MSK;
        need16_nxt = (OFF_W'(in_req.request_bytes) + ROUND_ADD + HDR_OFF) & GRAIN_MSK;
        pos_nxt    = BOOK_OFF;
        p_nxt      = in_req.object_address - heap_base_r;
      end
      ST_A_RD: begin
        st_rd_en = a_walk_ok;
        if (!a_walk_ok) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{payload_address: '0, status: STAT_NO_FIT};
        end
      end
      ST_A_CHK: begin
        sz_nxt = rd_size;
        if (!a_take) pos_nxt = walk_sum;
      end
      ST_A_FIT: begin
        rem_nxt = pos_r + need16_r;
        if (!a_fits) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{payload_address: '0, status: STAT_NO_FIT};
        end
      end
      ST_A_REM: begin
        // split off the remainder when its header still fits
        st_wr.en        = rem_fits;
        st_wr.addr      = rem_r[GRAIN_W +: IDX_W];
        st_wr.data.occ  = 1'b0;
        st_wr.data.size = SIZE_W'(sz_r - need16_r);
      end
      ST_A_HDR: begin
        st_wr.en        = 1'b1;
        st_wr.addr      = pos_r[GRAIN_W +: IDX_W];
        st_wr.data.occ  = 1'b1;
        st_wr.data.size = need_r[SIZE_W-1:0];
        out_valid_nxt   = 1'b1;
        out_res_nxt     = '{payload_address: heap_base_r + ADDR_W'(pos_r + HDR_OFF),
                            status: STAT_DONE};
      end
      ST_F_CHK: begin
        st_rd_en   = f_addr_ok;
        st_rd_addr = hdr_off[GRAIN_W +: IDX_W];
        if (!f_addr_ok) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{payload_address: '0, status: STAT_DONE};
        end
      end
      ST_F_CUR: begin
        cur_nxt = rd_size;
        pos_nxt = p_off + rd_size;
      end
      ST_F_LRD: begin
        st_rd_en = f_walk_ok;
      end
      ST_F_LCHK: begin
        // absorb the following free block and clear its header
        if (!f_stop) begin
          st_wr.en   = 1'b1;
          st_wr.addr = pos_r[GRAIN_W +: IDX_W];
          cur_nxt    = cur_r + rd_size + HDR_OFF;
          pos_nxt    = walk_sum;
        end
      end
      ST_F_HDR: begin
        st_wr.en        = 1'b1;
        st_wr.addr      = hdr_off[GRAIN_W +: IDX_W];
        st_wr.data.occ  = 1'b0;
        st_wr.data.size = cur_r[SIZE_W-1:0];
        out_valid_nxt   = 1'b1;
        out_res_nxt     = '{payload_address: '0, status: STAT_DONE};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    need_r    <= need_nxt;
    need16_r  <= need16_nxt;
    sz_r      <= sz_nxt;
    rem_r     <= rem_nxt;
    cur_r     <= cur_nxt;
    p_r       <= p_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== sv/ffba_checker.sv =====
module ffba_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input ffba_pkg::res_t out_res
);
  import ffba_pkg::*;

  // a taken request keeps the block busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after a request");

  // no result in the cycle straight after a request
  a_no_instant_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result one cycle after request");

  // a result strobe lasts a single cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");

  // a failed allocation returns address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status == STAT_NO_FIT)) |-> (out_res.payload_address == '0))
    else $error("failed allocation with nonzero address");

  // the header store is being cleared after reset
  a_clear_busy: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("not busy after reset");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

// ===== test/tb_first_fit_block_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_top;
  import ffba_pkg::*;

  // no request or result for this long means the block has hung
  localparam int unsigned STALL_LIMIT = 60000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  req_t              in_req = '0;
  logic              out_valid;
  res_t              out_res;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // mirror of the header store and the two registers
  hdr_t              heap_headers [STORE_DEPTH];
  logic [SIZE_W-1:0] heap_bytes_q = SIZE_W'(HEAP_BYTES);
  logic [ADDR_W-1:0] heap_base_q = '0;

  res_t              awaited_results [$];
  int unsigned       granted_offsets [$];
  res_t              head_result;
  int unsigned       fault_count = 0;
  int unsigned       stall_cycles = 0;
  bit                gaps_on = 1'b1;

  first_fit_block_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // effective heap end, clamped to the store size
  function automatic int unsigned heap_limit();
    if (heap_bytes_q > HEAP_BYTES) return HEAP_BYTES;
    return 32'(heap_bytes_q);
  endfunction

  function automatic hdr_t header_at(int unsigned off);
    if ((off >> GRAIN_W) < STORE_DEPTH) return heap_headers[IDX_W'(off >> GRAIN_W)];
    return '0;
  endfunction

  function automatic void store_header(int unsigned off, hdr_t h);
    if ((off >> GRAIN_W) < STORE_DEPTH) heap_headers[IDX_W'(off >> GRAIN_W)] = h;
  endfunction

  // first-fit walk from the end of the book area, then split and mark occupied
  function automatic res_t carve_block(logic [SIZE_W-1:0] req_bytes);
    int unsigned lim, need, pos, sz;
    hdr_t        h;
    bit          hit;
    res_t        outcome;
    lim = heap_limit();
    need = ({15'd0, req_bytes} + 32'd7) & ~32'd7;
    pos = BOOK_BYTES;
    sz = 0;
    hit = 1'b0;
    while (pos + HEADER_BYTES < lim) begin
      h = header_at(pos);
      sz = 32'(h.size);
      if (!h.occ && (sz == 0 || sz > need + HEADER_BYTES)) begin
        hit = 1'b1;
        break;
      end
      pos += sz + HEADER_BYTES;
    end
    outcome.payload_address = '0;
    outcome.status = STAT_NO_FIT;
    if (hit && pos + HEADER_BYTES + need <= lim) begin
      // remainder header only where it still fits inside the heap
      if (sz > need + HEADER_BYTES && pos + 2 * HEADER_BYTES + need <= lim) begin
        h.occ = 1'b0;
        h.size = SIZE_W'(sz - need - HEADER_BYTES);
        store_header(pos + HEADER_BYTES + need, h);
      end
      h.occ = 1'b1;
      h.size = SIZE_W'(need);
      store_header(pos, h);
      outcome.payload_address = heap_base_q + (pos + HEADER_BYTES);
      outcome.status = STAT_DONE;
    end
    return outcome;
  endfunction

  // mark a block free and swallow the free blocks behind it
  function automatic void release_block(logic [ADDR_W-1:0] addr);
    int unsigned lim, p, hdr_off, cur, pos, s;
    hdr_t        h;
    lim = heap_limit();
    p = addr - heap_base_q;
    if ((p % GRAIN_BYTES) != 0 || p < BOOK_BYTES + HEADER_BYTES || p > lim) return;
    hdr_off = p - HEADER_BYTES;
    h = header_at(hdr_off);
    cur = 32'(h.size);
    pos = p + cur;
    while (pos >= p && pos + HEADER_BYTES <= lim) begin
      h = header_at(pos);
      s = 32'(h.size);
      if (h.occ || pos + HEADER_BYTES + s > lim) break;
      cur += s + HEADER_BYTES;
      store_header(pos, '0);
      pos += s + HEADER_BYTES;
    end
    h.occ = 1'b0;
    h.size = SIZE_W'(cur);
    store_header(hdr_off, h);
  endfunction

  function automatic res_t serve_request(req_t rq);
    res_t outcome;
    outcome = '0;
    outcome.status = STAT_DONE;
    if (rq.cmd == CMD_ALLOC) outcome = carve_block(rq.request_bytes);
    else release_block(rq.object_address);
    return outcome;
  endfunction

  // unused fields carry random junk
  function automatic req_t alloc_request(int unsigned bytes);
    req_t rq;
    rq.cmd = CMD_ALLOC;
    rq.request_bytes = SIZE_W'(bytes);
    rq.object_address = $urandom;
    return rq;
  endfunction

  function automatic req_t free_request(logic [ADDR_W-1:0] addr);
    req_t rq;
    rq.cmd = CMD_FREE;
    rq.request_bytes = SIZE_W'($urandom_range(0, 65536));
    rq.object_address = addr;
    return rq;
  endfunction

  // hold start until the block takes the request, then predict its result
  task automatic issue_request(req_t rq);
    res_t outcome;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk) start <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    outcome = serve_request(rq);
    awaited_results.push_back(outcome);
    if (rq.cmd == CMD_ALLOC && outcome.status == STAT_DONE)
      granted_offsets.push_back(outcome.payload_address - heap_base_q);
  endtask

  // wait for every outstanding result and for the block to go idle
  task automatic settle_block();
    @(negedge clk) start <= 1'b0;
    while (awaited_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEAP_BYTES) heap_bytes_q = value[SIZE_W-1:0];
    else heap_base_q = value;
  endtask

  task automatic test_small_heap_cases();
    settle_block();
    program_register(CFG_HEAP_BYTES, 128);
    program_register(CFG_HEAP_BASE, 32'h0000_1000);
    // payload larger than the whole heap
    issue_request(alloc_request(65536));
    // fills the heap exactly
    issue_request(alloc_request(100));
    // walk runs off the end
    issue_request(alloc_request(1));
    issue_request(free_request(32'h0000_1018));
    // split of a free block, twice, then nothing left that fits
    issue_request(alloc_request(40));
    issue_request(alloc_request(24));
    issue_request(alloc_request(0));
    // bad addresses: misaligned, in the book area, past the end, below the base
    issue_request(free_request(32'h0000_1019));
    issue_request(free_request(32'h0000_1010));
    issue_request(free_request(32'h0000_1088));
    issue_request(free_request(32'h0000_0ff8));
    // frees that merge with the free blocks behind them
    issue_request(free_request(32'h0000_1050));
    issue_request(free_request(32'h0000_1018));
    // shrink the heap under a free block so the remainder header falls off
    settle_block();
    program_register(CFG_HEAP_BYTES, 96);
    issue_request(alloc_request(64));
    issue_request(free_request(32'h0000_1018));
    // an address in the middle of a block is taken as a header
    issue_request(free_request(32'h0000_1030));
  endtask

  task automatic test_heap_extremes();
    settle_block();
    // size register above the store size acts as the full store
    program_register(CFG_HEAP_BYTES, 32'h0001_ffff);
    program_register(CFG_HEAP_BASE, 32'hffff_fff0);
    issue_request(alloc_request(65535));
    // payload address wraps past zero
    issue_request(alloc_request(8));
    issue_request(free_request(32'h0000_0008));
    // tiny heap
    settle_block();
    program_register(CFG_HEAP_BYTES, 32);
    program_register(CFG_HEAP_BASE, 32'h0000_0000);
    issue_request(alloc_request(0));
    issue_request(alloc_request(8));
    issue_request(free_request(32'h0000_0018));
    // heap of 64 bytes with the top base
    settle_block();
    program_register(CFG_HEAP_BYTES, 64);
    program_register(CFG_HEAP_BASE, 32'hffff_ffff);
    issue_request(alloc_request(16));
    issue_request(free_request(32'h0000_0017));
    issue_request(alloc_request(65536));
  endtask

  // one heap setting: mostly allocate and free of live blocks, some stray requests
  task automatic run_traffic_phase(int unsigned items, bit with_gaps);
    int unsigned       lim, pick, slot, off;
    logic [ADDR_W-1:0] base;
    settle_block();
    pick = $urandom_range(0, 9);
    if (pick == 0) lim = HEAP_BYTES;
    else if (pick == 1) lim = 64;
    else if (pick == 2) lim = $urandom_range(64, HEAP_BYTES);
    else lim = $urandom_range(64, 2048);
    pick = $urandom_range(0, 5);
    if (pick == 0) base = '0;
    else if (pick == 1) base = '1;
    else base = $urandom;
    program_register(CFG_HEAP_BYTES, lim);
    program_register(CFG_HEAP_BASE, base);
    gaps_on = with_gaps;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        issue_request(free_request($urandom));
      end else if (pick < 9) begin
        issue_request(free_request(base + ($urandom_range(0, lim + 16) & ~32'd7)));
      end else if (pick < 12 && granted_offsets.size() != 0) begin
        slot = $urandom_range(0, granted_offsets.size() - 1);
        issue_request(free_request(base + granted_offsets[slot] + $urandom_range(1, 7)));
      end else if (pick < 15) begin
        issue_request(alloc_request($urandom_range(0, 65536)));
      end else if (pick < 55 && granted_offsets.size() != 0) begin
        slot = $urandom_range(0, granted_offsets.size() - 1);
        off = granted_offsets[slot];
        granted_offsets.delete(slot);
        issue_request(free_request(base + off));
      end else if ($urandom_range(0, 3) == 0) begin
        issue_request(alloc_request($urandom_range(0, lim)));
      end else begin
        issue_request(alloc_request($urandom_range(0, lim / 8)));
      end
    end
    // hand back everything still held before the next setting
    while (granted_offsets.size() != 0) begin
      off = granted_offsets.pop_front();
      issue_request(free_request(base + off));
    end
  endtask

  task automatic test_random_traffic();
    repeat (13) run_traffic_phase(100, $urandom_range(0, 2) != 0);
  endtask

  task automatic test_back_to_back();
    repeat (3) run_traffic_phase(100, 1'b0);
  endtask

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: payload_address %h status %b",
               out_res.payload_address, out_res.status);
        fault_count++;
      end else begin
        head_result = awaited_results.pop_front();
        if (out_res.payload_address !== head_result.payload_address) begin
          $error("payload_address: expected %h, got %h",
                 head_result.payload_address, out_res.payload_address);
          fault_count++;
        end
        if (out_res.status !== head_result.status) begin
          $error("status: expected %b, got %b", head_result.status, out_res.status);
          fault_count++;
        end
      end
    end
  end

  // hang detection
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (heap_headers[i]) heap_headers[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_small_heap_cases();
    test_heap_extremes();
    test_random_traffic();
    test_back_to_back();
    settle_block();
    repeat (40) @(posedge clk);
    if (fault_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== first_fit_block_allocator_top.f =====
sv/ffba_pkg.sv
sv/ffba_hdr_store.sv
sv/first_fit_block_allocator_top.sv
sv/ffba_checker.sv
test/tb_first_fit_block_allocator_top.sv
